>>> rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define MHPQ_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Same-cycle implication.
`define MHPQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MHPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mhpq_pkg.sv
`default_nettype none

package mhpq_pkg;

  localparam int DEF_CAPACITY  = 256;
  localparam int DEF_KEY_WIDTH = 16;
  localparam int DEF_TAG_WIDTH = 8;

  localparam int STATUS_WIDTH = 2;

  // Operation codes of a request
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  localparam logic [STATUS_WIDTH-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd2;

  // Control handed from the heap engine to the result buffer
  typedef struct packed {
    logic                    valid;
    logic [STATUS_WIDTH-1:0] status;
  } res_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/mhpq_ifs.sv
`default_nettype none

interface mhpq_in_if #(
  parameter int KEY_WIDTH = mhpq_pkg::DEF_KEY_WIDTH,
  parameter int TAG_WIDTH = mhpq_pkg::DEF_TAG_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [KEY_WIDTH-1:0] key;
  logic [TAG_WIDTH-1:0] tag;

  modport source (output valid, output op, output key, output tag, input ready);
  modport sink   (input valid, input op, input key, input tag, output ready);
endinterface

interface mhpq_out_if #(
  parameter int CAPACITY  = mhpq_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = mhpq_pkg::DEF_KEY_WIDTH,
  parameter int TAG_WIDTH = mhpq_pkg::DEF_TAG_WIDTH,
  parameter int CNT_WIDTH = $clog2(CAPACITY + 1)
);
  logic                              valid;
  logic                              ready;
  logic [KEY_WIDTH-1:0]              out_key;
  logic [TAG_WIDTH-1:0]              out_tag;
  logic [mhpq_pkg::STATUS_WIDTH-1:0] status;
  logic [CNT_WIDTH-1:0]              count;

  modport source (output valid, output out_key, output out_tag, output status,
                  output count, input ready);
  modport sink   (input valid, input out_key, input out_tag, input status,
                  input count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/min_heap_priority_queue.sv
// Channel  Dir  Fields                          Transfer
// in_req   in   op, key, tag                    valid & ready
// out_rsp  out  out_key, out_tag, status, count valid & ready
//
// One request at a time, one response each; a refused one (full or empty) goes straight to the response.
// Insert: written at the root of an empty queue, else the entry climbs one level per compare.
// Remove: read the root and the last entry, then per level read the left and right child and compare
//   (the left child only if no right one exists); a hole that settles at a leaf takes a final write.
// Reset clears the fill count, the engine state and the output valid; the heap memory needs no clearing pass.
// A stalled response sits in the output register while the next request runs.

`default_nettype none

module min_heap_priority_queue #(
  parameter int CAPACITY  = mhpq_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = mhpq_pkg::DEF_KEY_WIDTH,
  parameter int TAG_WIDTH = mhpq_pkg::DEF_TAG_WIDTH,
  localparam int CNT_WIDTH = $clog2(CAPACITY + 1)
) (
  input wire logic   clk,
  input wire logic   rst_n,
  mhpq_in_if.sink    in_req,
  mhpq_out_if.source out_rsp
);

  // Engine to output register: result control, payload and backpressure
  mhpq_pkg::res_ctrl_t  res_ctrl;
  logic                 res_ready;
  logic [KEY_WIDTH-1:0] res_key;
  logic [TAG_WIDTH-1:0] res_tag;
  logic [CNT_WIDTH-1:0] res_count;

  // Heap engine: owns the entry memory and the fill count, runs the
  // sift-up and sift-down walks as read-compare-write steps.
  mhpq_engine #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .res_ctrl  (res_ctrl),
    .res_ready (res_ready),
    .res_key   (res_key),
    .res_tag   (res_tag),
    .res_count (res_count)
  );

  // Output register: hold a response until the sink takes it, so the
  // engine can accept and work on the next request meanwhile.
  mhpq_outq #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_ctrl  (res_ctrl),
    .res_ready (res_ready),
    .res_key   (res_key),
    .res_tag   (res_tag),
    .res_count (res_count),
    .out_rsp   (out_rsp)
  );

endmodule

`default_nettype wire

>>> rtl/core/mhpq_ram.sv
`default_nettype none

module mhpq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int ADDR_WIDTH = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [ADDR_WIDTH-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]      wr_data,
  input  wire logic                  rd_en,
  input  wire logic [ADDR_WIDTH-1:0] rd_addr,
  output      logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/core/mhpq_engine.sv
`default_nettype none

module mhpq_engine #(
  parameter int CAPACITY  = mhpq_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = mhpq_pkg::DEF_KEY_WIDTH,
  parameter int TAG_WIDTH = mhpq_pkg::DEF_TAG_WIDTH,
  localparam int CNT_WIDTH   = $clog2(CAPACITY + 1),
  localparam int ADDR_WIDTH  = $clog2(CAPACITY),
  localparam int ENTRY_WIDTH = KEY_WIDTH + TAG_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  mhpq_in_if.sink                 in_req,
  output mhpq_pkg::res_ctrl_t     res_ctrl,
  input  wire logic               res_ready,
  output      logic [KEY_WIDTH-1:0] res_key,
  output      logic [TAG_WIDTH-1:0] res_tag,
  output      logic [CNT_WIDTH-1:0] res_count
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_UP_CMP   = 8'b0000_0010,
    S_RM_ROOT  = 8'b0000_0100,
    S_RM_LAST  = 8'b0000_1000,
    S_DN_LEFT  = 8'b0001_0000,
    S_DN_RIGHT = 8'b0010_0000,
    S_PUT      = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_t;

  localparam logic [CNT_WIDTH-1:0] POS_ROOT = CNT_WIDTH'(1);
  localparam logic [CNT_WIDTH-1:0] POS_KID  = CNT_WIDTH'(2);

  state_t state_r, state_nxt;

  logic [CNT_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic [CNT_WIDTH-1:0]   pos_r, pos_nxt;
  logic [KEY_WIDTH-1:0]   new_key_r, new_key_nxt;
  logic [TAG_WIDTH-1:0]   new_tag_r, new_tag_nxt;
  logic [ENTRY_WIDTH-1:0] left_r, left_nxt;
  logic [KEY_WIDTH-1:0]   res_key_r, res_key_nxt;
  logic [TAG_WIDTH-1:0]   res_tag_r, res_tag_nxt;
  logic [mhpq_pkg::STATUS_WIDTH-1:0] res_status_r, res_status_nxt;

  logic                   rd_en;
  logic [CNT_WIDTH-1:0]   rd_pos;
  logic [ENTRY_WIDTH-1:0] rd_data;
  logic                   wr_en;
  logic [CNT_WIDTH-1:0]   wr_pos;
  logic [ENTRY_WIDTH-1:0] wr_data;

  logic [KEY_WIDTH-1:0]   rd_key;
  logic [TAG_WIDTH-1:0]   rd_tag;
  logic [KEY_WIDTH-1:0]   left_key;
  logic [CNT_WIDTH:0]     cnt_ext;
  logic [CNT_WIDTH:0]     kid_lo;
  logic [CNT_WIDTH:0]     kid_hi;
  logic [CNT_WIDTH-1:0]   cnt_inc;
  logic [CNT_WIDTH-1:0]   par_pos;
  logic                   right_wins;
  logic [ENTRY_WIDTH-1:0] cho_entry;
  logic [KEY_WIDTH-1:0]   cho_key;
  logic [CNT_WIDTH-1:0]   cho_pos;
  logic [CNT_WIDTH:0]     next_kid;

  // Heap position (one-based) to memory address
  function automatic logic [ADDR_WIDTH-1:0] addr_of(input logic [CNT_WIDTH-1:0] pos);
    logic [CNT_WIDTH-1:0] zb;
    zb = pos - CNT_WIDTH'(1);
    return zb[ADDR_WIDTH-1:0];
  endfunction

  mhpq_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr_of(wr_pos)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (addr_of(rd_pos)),
    .rd_data (rd_data)
  );

  assign rd_key   = rd_data[ENTRY_WIDTH-1 -: KEY_WIDTH];
  assign rd_tag   = rd_data[TAG_WIDTH-1:0];
  assign left_key = left_r[ENTRY_WIDTH-1 -: KEY_WIDTH];
  assign cnt_ext  = {1'b0, cnt_r};
  assign kid_lo   = {pos_r, 1'b0};
  assign kid_hi   = {pos_r, 1'b1};
  assign cnt_inc  = cnt_r + CNT_WIDTH'(1);
  assign par_pos  = pos_r >> 1;

  // Pick the smaller child; the left one wins a tie
  assign right_wins = (state_r == S_DN_RIGHT) && (left_key > rd_key);
  assign cho_entry  = ((state_r == S_DN_RIGHT) && !right_wins) ? left_r : rd_data;
  assign cho_key    = cho_entry[ENTRY_WIDTH-1 -: KEY_WIDTH];
  assign cho_pos    = right_wins ? kid_hi[CNT_WIDTH-1:0] : kid_lo[CNT_WIDTH-1:0];
  assign next_kid   = {cho_pos, 1'b0};

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    new_key_nxt    = new_key_r;
    new_tag_nxt    = new_tag_r;
    left_nxt       = left_r;
    res_key_nxt    = res_key_r;
    res_tag_nxt    = res_tag_r;
    res_status_nxt = res_status_r;
    rd_en          = 1'b0;
    rd_pos         = pos_r;
    wr_en          = 1'b0;
    wr_pos         = pos_r;
    wr_data        = {new_key_r, new_tag_r};

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          new_key_nxt    = in_req.key;
          new_tag_nxt    = in_req.tag;
          res_key_nxt    = '0;
          res_tag_nxt    = '0;
          res_status_nxt = mhpq_pkg::STATUS_DONE;
          if (in_req.op == mhpq_pkg::OP_INSERT) begin
            if (cnt_r == CNT_WIDTH'(CAPACITY)) begin
              res_status_nxt = mhpq_pkg::STATUS_FULL;
              state_nxt      = S_FIN;
            end else begin
              cnt_nxt = cnt_inc;
              pos_nxt = cnt_inc;
              if (cnt_r == '0) begin
                wr_en     = 1'b1;
                wr_pos    = POS_ROOT;
                wr_data   = {in_req.key, in_req.tag};
                state_nxt = S_FIN;
              end else begin
                rd_en     = 1'b1;
                rd_pos    = cnt_inc >> 1;
                state_nxt = S_UP_CMP;
              end
            end
          end else begin
            if (cnt_r == '0) begin
              res_status_nxt = mhpq_pkg::STATUS_EMPTY;
              state_nxt      = S_FIN;
            end else begin
              rd_en     = 1'b1;
              rd_pos    = POS_ROOT;
              state_nxt = S_RM_ROOT;
            end
          end
        end
      end

      S_UP_CMP: begin
        if (new_key_r < rd_key) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          pos_nxt = par_pos;
          if (par_pos == POS_ROOT) begin
            state_nxt = S_PUT;
          end else begin
            rd_en  = 1'b1;
            rd_pos = par_pos >> 1;
          end
        end else begin
          wr_en     = 1'b1;
          state_nxt = S_FIN;
        end
      end

      S_RM_ROOT: begin
        res_key_nxt = rd_key;
        res_tag_nxt = rd_tag;
        cnt_nxt     = cnt_r - CNT_WIDTH'(1);
        rd_en       = 1'b1;
        rd_pos      = cnt_r;
        state_nxt   = S_RM_LAST;
      end

      S_RM_LAST: begin
        new_key_nxt = rd_key;
        new_tag_nxt = rd_tag;
        pos_nxt     = POS_ROOT;
        if (POS_KID <= cnt_r) begin
          rd_en     = 1'b1;
          rd_pos    = POS_KID;
          state_nxt = S_DN_LEFT;
        end else begin
          state_nxt = S_PUT;
        end
      end

      S_DN_LEFT, S_DN_RIGHT: begin
        if ((state_r == S_DN_LEFT) && (kid_lo < cnt_ext)) begin
          left_nxt  = rd_data;
          rd_en     = 1'b1;
          rd_pos    = kid_hi[CNT_WIDTH-1:0];
          state_nxt = S_DN_RIGHT;
        end else if (new_key_r <= cho_key) begin
          wr_en     = 1'b1;
          state_nxt = S_FIN;
        end else begin
          wr_en   = 1'b1;
          wr_data = cho_entry;
          pos_nxt = cho_pos;
          if (next_kid <= cnt_ext) begin
            rd_en     = 1'b1;
            rd_pos    = next_kid[CNT_WIDTH-1:0];
            state_nxt = S_DN_LEFT;
          end else begin
            state_nxt = S_PUT;
          end
        end
      end

      S_PUT: begin
        wr_en     = 1'b1;
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    new_key_r    <= new_key_nxt;
    new_tag_r    <= new_tag_nxt;
    left_r       <= left_nxt;
    res_key_r    <= res_key_nxt;
    res_tag_r    <= res_tag_nxt;
    res_status_r <= res_status_nxt;
  end

  assign in_req.ready    = (state_r == S_IDLE);
  assign res_ctrl.valid  = (state_r == S_FIN);
  assign res_ctrl.status = res_status_r;
  assign res_key         = res_key_r;
  assign res_tag         = res_tag_r;
  assign res_count       = cnt_r;

endmodule

`default_nettype wire

>>> rtl/core/mhpq_outq.sv
`default_nettype none

module mhpq_outq #(
  parameter int CAPACITY  = mhpq_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = mhpq_pkg::DEF_KEY_WIDTH,
  parameter int TAG_WIDTH = mhpq_pkg::DEF_TAG_WIDTH,
  localparam int CNT_WIDTH = $clog2(CAPACITY + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mhpq_pkg::res_ctrl_t  res_ctrl,
  output      logic                 res_ready,
  input  wire logic [KEY_WIDTH-1:0] res_key,
  input  wire logic [TAG_WIDTH-1:0] res_tag,
  input  wire logic [CNT_WIDTH-1:0] res_count,
  mhpq_out_if.source                out_rsp
);

  logic                              valid_r, valid_nxt;
  logic [KEY_WIDTH-1:0]              key_r;
  logic [TAG_WIDTH-1:0]              tag_r;
  logic [mhpq_pkg::STATUS_WIDTH-1:0] status_r;
  logic [CNT_WIDTH-1:0]              count_r;
  logic                              load;

  // Take a new result when the slot is empty or being drained
  assign res_ready = !valid_r || out_rsp.ready;
  assign load      = res_ctrl.valid && res_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_r    <= res_key;
      tag_r    <= res_tag;
      status_r <= res_ctrl.status;
      count_r  <= res_count;
    end
  end

  assign out_rsp.valid   = valid_r;
  assign out_rsp.out_key = key_r;
  assign out_rsp.out_tag = tag_r;
  assign out_rsp.status  = status_r;
  assign out_rsp.count   = count_r;

endmodule

`default_nettype wire

>>> rtl/core/mhpq_checker.sv
`default_nettype none

`include "assert_macros.svh"

module mhpq_checker #(
  parameter int CAPACITY  = mhpq_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = mhpq_pkg::DEF_KEY_WIDTH,
  parameter int TAG_WIDTH = mhpq_pkg::DEF_TAG_WIDTH,
  localparam int CNT_WIDTH = $clog2(CAPACITY + 1)
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [KEY_WIDTH-1:0]              out_key,
  input wire logic [TAG_WIDTH-1:0]              out_tag,
  input wire logic [mhpq_pkg::STATUS_WIDTH-1:0] out_status,
  input wire logic [CNT_WIDTH-1:0]              out_count
);

  // Requests taken whose responses are not yet delivered
  logic [1:0] pending_r, pending_nxt;

  assign pending_nxt = pending_r + {1'b0, in_valid && in_ready}
                       - {1'b0, out_valid && out_ready};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `MHPQ_ASSERT(a_no_orphan_rsp, !out_valid || (pending_r != 2'd0), "response without request")
  `MHPQ_ASSERT(a_count_range, !out_valid || (out_count <= CNT_WIDTH'(CAPACITY)), "count above capacity")
  `MHPQ_ASSERT_IMPL(a_full_count, out_valid && (out_status == mhpq_pkg::STATUS_FULL), (out_count == CNT_WIDTH'(CAPACITY)) && (out_key == '0) && (out_tag == '0), "full refusal with bad fields")
  `MHPQ_ASSERT_IMPL(a_empty_count, out_valid && (out_status == mhpq_pkg::STATUS_EMPTY), (out_count == '0) && (out_key == '0) && (out_tag == '0), "empty refusal with bad fields")
  `MHPQ_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid, "response dropped under stall")

endmodule

bind min_heap_priority_queue mhpq_checker #(
  .CAPACITY  (CAPACITY),
  .KEY_WIDTH (KEY_WIDTH),
  .TAG_WIDTH (TAG_WIDTH)
) u_mhpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_key    (out_rsp.out_key),
  .out_tag    (out_rsp.out_tag),
  .out_status (out_rsp.status),
  .out_count  (out_rsp.count)
);

`default_nettype wire

>>> bench/tb_min_heap_priority_queue.sv
module tb_min_heap_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import mhpq_pkg::*;

  localparam int CAPACITY  = DEF_CAPACITY;
  localparam int KEY_WIDTH = DEF_KEY_WIDTH;
  localparam int TAG_WIDTH = DEF_TAG_WIDTH;
  localparam int CNT_WIDTH = $clog2(CAPACITY + 1);
  // Longest legal stretch without any request or response moving is the
  // receiver hold-off plus one slow remove; allow plenty more.
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [TAG_WIDTH-1:0] tag;
  } heap_entry_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]    key;
    logic [TAG_WIDTH-1:0]    tag;
    logic [STATUS_WIDTH-1:0] status;
    logic [CNT_WIDTH-1:0]    count;
  } heap_response_t;

  logic clk;
  logic rst_n;

  mhpq_in_if  #(.KEY_WIDTH(KEY_WIDTH), .TAG_WIDTH(TAG_WIDTH)) in_ch ();
  mhpq_out_if #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH), .TAG_WIDTH(TAG_WIDTH)) out_ch ();

  min_heap_priority_queue #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH),
    .TAG_WIDTH(TAG_WIDTH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_ch),
    .out_rsp(out_ch)
  );

  // Shadow copy of the heap: one-based array plus fill count, updated on
  // every accepted request in the same order the block sees them.
  heap_entry_t shadow_heap [1:CAPACITY];
  int          shadow_count;

  // Responses still owed by the block, oldest first.
  heap_response_t pending_responses [$];

  int          errors;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int          hold_request;
  int          stall_cycles;

  // Apply one request to the shadow heap and return the response it owes.
  function automatic heap_response_t heap_outcome(input logic op,
                                                  input logic [KEY_WIDTH-1:0] key,
                                                  input logic [TAG_WIDTH-1:0] tag);
    heap_response_t rsp;
    heap_entry_t    top;
    heap_entry_t    moved;
    int             pos;
    int             kid;
    rsp = '0;
    if (op == OP_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        rsp.status = STATUS_FULL;
      end else begin
        // Climb while strictly smaller than the parent; equal keys stay put.
        shadow_count++;
        pos = shadow_count;
        while (pos != 1 && key < shadow_heap[pos / 2].key) begin
          shadow_heap[pos] = shadow_heap[pos / 2];
          pos = pos / 2;
        end
        shadow_heap[pos] = '{key: key, tag: tag};
        rsp.status = STATUS_DONE;
      end
    end else if (shadow_count == 0) begin
      rsp.status = STATUS_EMPTY;
    end else begin
      // Take the root, move the last entry into the hole and sink it toward
      // the smaller child (left on a tie), stopping on less-or-equal.
      top   = shadow_heap[1];
      moved = shadow_heap[shadow_count];
      shadow_count--;
      pos = 1;
      kid = 2;
      while (kid <= shadow_count) begin
        if (kid < shadow_count && shadow_heap[kid].key > shadow_heap[kid + 1].key)
          kid++;
        if (moved.key <= shadow_heap[kid].key)
          break;
        shadow_heap[pos] = shadow_heap[kid];
        pos = kid;
        kid = kid * 2;
      end
      shadow_heap[pos] = moved;
      rsp.key    = top.key;
      rsp.tag    = top.tag;
      rsp.status = STATUS_DONE;
    end
    rsp.count = shadow_count[CNT_WIDTH-1:0];
    return rsp;
  endfunction

  function automatic void compare_field(input string what, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  // Clock: 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: pick ready at each falling edge; a hold-off request from a
  // test forces ready low for that many cycles, counted here.
  initial begin : drive_ready
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every accepted response against the oldest pending one.
  always @(posedge clk) begin : check_responses
    heap_response_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected response, expected none, %s %0d %0d %0d %0d",
                 $time, "got key, tag, status, count", out_ch.out_key, out_ch.out_tag,
                 out_ch.status, out_ch.count);
        errors++;
      end else begin
        want = pending_responses.pop_front();
        compare_field("out_key", 32'(want.key), 32'(out_ch.out_key));
        compare_field("out_tag", 32'(want.tag), 32'(out_ch.out_tag));
        compare_field("status", 32'(want.status), 32'(out_ch.status));
        compare_field("count", 32'(want.count), 32'(out_ch.count));
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one request, with a random gap first; predict on acceptance.
  task automatic send_request(input logic op, input logic [KEY_WIDTH-1:0] key,
                              input logic [TAG_WIDTH-1:0] tag);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.op    = op;
    in_ch.key   = key;
    in_ch.tag   = tag;
    do @(posedge clk); while (!in_ch.ready);
    pending_responses.push_back(heap_outcome(op, key, tag));
  endtask

  // Drop valid and hold until every owed response has come back.
  task automatic wait_for_responses;
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  // Key mix: dense small keys for ties, the extremes, or anything.
  function automatic logic [KEY_WIDTH-1:0] pick_key;
    case ($urandom_range(3))
      0:       return KEY_WIDTH'($urandom_range(7));
      1:       return $urandom_range(1) ? {KEY_WIDTH{1'b1}} : {KEY_WIDTH{1'b0}};
      default: return KEY_WIDTH'($urandom);
    endcase
  endfunction

  // Random tag of the payload width.
  function automatic logic [TAG_WIDTH-1:0] pick_tag;
    return TAG_WIDTH'($urandom);
  endfunction

  // Extremes, ties, remove of the last entry and remove on empty.
  task automatic test_directed;
    send_request(OP_REMOVE, 16'h1234, 8'h12);   // empty queue
    send_request(OP_INSERT, 16'hFFFF, 8'hFF);
    send_request(OP_INSERT, 16'h0000, 8'h00);
    send_request(OP_INSERT, 16'h8000, 8'h55);
    send_request(OP_INSERT, 16'h8000, 8'hAA);   // climbs past 16'hFFFF; equal to its sibling
    send_request(OP_INSERT, 16'h8000, 8'h0F);
    send_request(OP_INSERT, 16'h7FFF, 8'hF0);
    repeat (6) send_request(OP_REMOVE, 16'hFFFF, 8'hFF);  // last one empties it
    send_request(OP_REMOVE, 16'h0000, 8'h00);   // empty again
    // Equal children: the sift down must prefer the left one and stop.
    send_request(OP_INSERT, 16'd0, 8'd1);
    send_request(OP_INSERT, 16'd5, 8'd2);
    send_request(OP_INSERT, 16'd5, 8'd3);
    send_request(OP_INSERT, 16'd5, 8'd4);
    send_request(OP_INSERT, 16'd5, 8'd5);
    repeat (5) send_request(OP_REMOVE, 16'd0, 8'd0);
  endtask

  // Fill to capacity, push against the full queue, drain past empty.
  task automatic test_full_queue;
    while (shadow_count < CAPACITY)
      send_request(OP_INSERT, pick_key(), pick_tag());
    repeat (3) send_request(OP_INSERT, pick_key(), pick_tag());
    while (shadow_count > 0)
      send_request(OP_REMOVE, pick_key(), pick_tag());
    repeat (2) send_request(OP_REMOVE, pick_key(), pick_tag());
  endtask

  // Random inserts and removes; drift the fill level toward a moving goal
  // so sifts run at every depth and the queue empties now and then.
  task automatic test_random_traffic(input int n_requests);
    int   fill_goal;
    logic op;
    fill_goal = 0;
    for (int i = 0; i < n_requests; i++) begin
      if (i % 64 == 0)
        fill_goal = $urandom_range(CAPACITY);
      if (shadow_count < fill_goal)
        op = ($urandom_range(99) < 75) ? OP_INSERT : OP_REMOVE;
      else
        op = ($urandom_range(99) < 25) ? OP_INSERT : OP_REMOVE;
      send_request(op, pick_key(), pick_tag());
    end
  endtask

  // Hold the receiver off for a long stretch while requests keep coming,
  // so the output register fills and the input stalls.
  task automatic test_backpressure;
    hold_request = 300;
    for (int i = 0; i < 40; i++)
      send_request(($urandom_range(99) < 60) ? OP_INSERT : OP_REMOVE, pick_key(), pick_tag());
    wait_for_responses();
  endtask

  initial begin
    errors         = 0;
    shadow_count   = 0;
    hold_request   = 0;
    stall_cycles   = 0;
    send_gap_pct   = 13;
    recv_stall_pct = 47;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_INSERT;
    in_ch.key      = '0;
    in_ch.tag      = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Sender sparse, receiver stalls often.
    test_directed();
    test_full_queue();
    test_random_traffic(200);
    wait_for_responses();

    // Sender stalls often, receiver sparse.
    send_gap_pct   = 47;
    recv_stall_pct = 13;
    test_random_traffic(240);
    test_backpressure();

    // No idling on either side.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_traffic(240);
    wait_for_responses();

    // Let any stray response show up before closing.
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_responses.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_ifs.sv
rtl/core/mhpq_ram.sv
rtl/core/mhpq_engine.sv
rtl/core/mhpq_outq.sv
rtl/core/min_heap_priority_queue.sv
rtl/core/mhpq_checker.sv
bench/tb_min_heap_priority_queue.sv
